>>> hdl/cssws_pkg.sv
`default_nettype none
package cssws_pkg;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SP  = 8'h20;

    localparam logic [2:0] MODE_NORMAL   = 3'd0;
    localparam logic [2:0] MODE_NOWRAP   = 3'd1;
    localparam logic [2:0] MODE_PRE_LINE = 3'd2;
    localparam logic [2:0] MODE_PRE      = 3'd3;
    localparam logic [2:0] MODE_PRE_WRAP = 3'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] ch;
        logic [2:0] mode;
        logic       node_end;
    } in_item_t;

    typedef struct packed {
        logic       has_char;
        logic [7:0] out_char;
        logic       node_done;
        logic       collapse_next;
        logic       last_of_run;
    } result_t;

    // up to two results produced by one byte
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage
`default_nettype wire

>>> hdl/css_whitespace_collapse_stream_core.sv
// A byte is registered in the input stage, and its results are then written to
// the result queue. One byte is taken per cycle while the queue has room; a byte
// that yields two results (flushed space plus its own byte) is absorbed by the
// 4-entry queue. Input is taken whenever the queue has two free entries.
// Reset: asynchronous, clears whitespace state and empties input stage and queue.
`default_nettype none
module css_whitespace_collapse_stream_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] ch,
    input  wire logic [2:0] mode,
    input  wire logic       node_end,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            has_char,
    output logic [7:0]      out_char,
    output logic            node_done,
    output logic            collapse_next,
    output logic            last_of_run
);
    import cssws_pkg::*;

    in_item_t in_item;
    in_item_t item;
    logic     item_valid;
    logic     take;
    logic     room;
    push_t    push;
    result_t  head;

    assign in_item.ch       = ch;
    assign in_item.mode     = mode;
    assign in_item.node_end = node_end;

    cssws_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .take       (take)
    );

    cssws_proc u_proc (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .room       (room),
        .take       (take),
        .push       (push)
    );

    cssws_res_queue u_res_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .head       (head)
    );

    assign has_char      = head.has_char;
    assign out_char      = head.out_char;
    assign node_done     = head.node_done;
    assign collapse_next = head.collapse_next;
    assign last_of_run   = head.last_of_run;

endmodule
`default_nettype wire

>>> hdl/cssws_in_stage.sv
`default_nettype none
module cssws_in_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire cssws_pkg::in_item_t in_item,
    output logic                    item_valid,
    output cssws_pkg::in_item_t     item,
    input  wire logic               take
);
    import cssws_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule
`default_nettype wire

>>> hdl/cssws_proc.sv
`default_nettype none
module cssws_proc (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    input  wire cssws_pkg::in_item_t item,
    input  wire logic                room,
    output logic                     take,
    output cssws_pkg::push_t         push
);
    import cssws_pkg::*;

    logic cr_seen_reg, cr_seen_next;
    logic after_lf_reg, after_lf_next;
    logic space_pending_reg, space_pending_next;
    logic collapsing_reg, collapsing_next;

    logic [7:0] c;
    logic       cm;
    logic [7:0] e0;
    logic [7:0] e1;
    logic [1:0] cnt;
    logic [1:0] n;
    logic       last0;

    assign take = item_valid && room;

    always_comb
    begin
        c                  = item.ch;
        cm                 = (item.mode == MODE_NORMAL) || (item.mode == MODE_NOWRAP) ||
                             (item.mode == MODE_PRE_LINE);
        cr_seen_next       = cr_seen_reg;
        after_lf_next      = after_lf_reg;
        space_pending_next = space_pending_reg;
        collapsing_next    = collapsing_reg;
        e0                 = 8'h00;
        e1                 = 8'h00;
        cnt                = 2'd0;

        if (cr_seen_reg && (c == CH_LF))
        begin
            // LF of a CR LF pair: swallowed
            cr_seen_next = 1'b0;
        end
        else
        begin
            if (c == CH_CR)
            begin
                c            = CH_LF;
                cr_seen_next = 1'b1;
            end
            else
            begin
                cr_seen_next = 1'b0;
            end

            if (!cm)
            begin
                if (space_pending_next)
                begin
                    if (!collapsing_next)
                    begin
                        e0  = CH_SP;
                        cnt = 2'd1;
                    end
                    collapsing_next    = 1'b1;
                    space_pending_next = 1'b0;
                end
                after_lf_next = 1'b0;
                if (cnt == 2'd0)
                begin
                    e0 = c;
                end
                else
                begin
                    e1 = c;
                end
                cnt = cnt + 2'd1;
            end
            else if (c == CH_LF)
            begin
                space_pending_next = 1'b0;
                after_lf_next      = 1'b1;
                if (item.mode == MODE_PRE_LINE)
                begin
                    e0              = CH_LF;
                    cnt             = 2'd1;
                    collapsing_next = 1'b0;
                end
                else
                begin
                    if (!collapsing_next)
                    begin
                        e0  = CH_SP;
                        cnt = 2'd1;
                    end
                    collapsing_next = 1'b1;
                end
            end
            else if ((c == CH_SP) || (c == CH_TAB))
            begin
                if (!after_lf_next)
                begin
                    space_pending_next = 1'b1;
                end
            end
            else
            begin
                after_lf_next = 1'b0;
                if (space_pending_next)
                begin
                    if (!collapsing_next)
                    begin
                        e0  = CH_SP;
                        cnt = 2'd1;
                    end
                    space_pending_next = 1'b0;
                end
                if (cnt == 2'd0)
                begin
                    e0 = c;
                end
                else
                begin
                    e1 = c;
                end
                cnt             = cnt + 2'd1;
                collapsing_next = 1'b0;
            end
        end

        if (item.node_end)
        begin
            // flush held whitespace at end of node
            if (space_pending_next)
            begin
                if (!collapsing_next)
                begin
                    if (cnt == 2'd0)
                    begin
                        e0 = CH_SP;
                    end
                    else
                    begin
                        e1 = CH_SP;
                    end
                    cnt = cnt + 2'd1;
                end
                collapsing_next = 1'b1;
            end
            cr_seen_next       = 1'b0;
            after_lf_next      = 1'b0;
            space_pending_next = 1'b0;
        end

        n     = (item.node_end && (cnt == 2'd0)) ? 2'd1 : cnt;
        last0 = (n == 2'd1);

        push.n                = take ? n : 2'd0;
        push.r0.has_char      = (cnt != 2'd0);
        push.r0.out_char      = e0;
        push.r0.node_done     = last0 && item.node_end;
        push.r0.collapse_next = last0 && item.node_end && cm && collapsing_next;
        push.r0.last_of_run   = last0;
        push.r1.has_char      = (cnt == 2'd2);
        push.r1.out_char      = e1;
        push.r1.node_done     = item.node_end;
        push.r1.collapse_next = item.node_end && cm && collapsing_next;
        push.r1.last_of_run   = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr_seen_reg       <= 1'b0;
            after_lf_reg      <= 1'b0;
            space_pending_reg <= 1'b0;
            collapsing_reg    <= 1'b0;
        end
        else if (take)
        begin
            cr_seen_reg       <= cr_seen_next;
            after_lf_reg      <= after_lf_next;
            space_pending_reg <= space_pending_next;
            collapsing_reg    <= collapsing_next;
        end
    end

    a_node_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (take && item.node_end) |=> (!cr_seen_reg && !after_lf_reg && !space_pending_reg))
        else $error("node end left per-node state set");

    a_node_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (take && item.node_end) |-> (push.n != 2'd0))
        else $error("node end produced no result");

    a_push_limit: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd3)
        else $error("more than two results from one byte");

endmodule
`default_nettype wire

>>> hdl/cssws_res_queue.sv
`default_nettype none
module cssws_res_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cssws_pkg::push_t   push,
    output logic                    room,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cssws_pkg::result_t      head
);
    import cssws_pkg::*;

    result_t           mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pop;

    // two free slots needed for a worst-case byte
    assign room      = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.n) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2)
        begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push.r1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> room)
        else $error("result queue written without room");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue count out of range");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CNT_W'(1) && pop && push.n == 2'd0) |=> !out_valid)
        else $error("result queue did not drain");

endmodule
`default_nettype wire

>>> tb/css_whitespace_collapse_stream_core_tb.sv
`timescale 1ns / 100ps

import cssws_pkg::*;

// Tracks the whitespace state of the stream and holds the output bytes still owed.
class ws_collapse_scoreboard;
    logic cr_seen;
    logic after_lf;
    logic space_held;
    logic collapsing;
    logic [7:0] emitted[$];
    result_t results_due[$];
    int errors;
    int lines_printed;

    function new();
        cr_seen = 1'b0;
        after_lf = 1'b0;
        space_held = 1'b0;
        collapsing = 1'b0;
        errors = 0;
        lines_printed = 0;
    endfunction

    function void report(string what);
        errors++;
        if (lines_printed < 200)
        begin
            $display("%0t: %s", $time, what);
            lines_printed++;
        end
    endfunction

    // held whitespace leaves as at most one space
    function void flush_held();
        if (space_held)
        begin
            if (!collapsing)
                emitted = {emitted, CH_SP};
            collapsing = 1'b1;
            space_held = 1'b0;
        end
    endfunction

    function void note_request(logic [7:0] ch_in, logic [2:0] md, logic last);
        logic [7:0] c;
        logic collapse_md;
        int n;
        result_t r;

        c = ch_in;
        collapse_md = (md <= MODE_PRE_LINE);
        emitted = {};
        if (cr_seen && c == CH_LF)
            cr_seen = 1'b0;
        else
        begin
            if (c == CH_CR)
            begin
                c = CH_LF;
                cr_seen = 1'b1;
            end
            else
                cr_seen = 1'b0;
            if (!collapse_md)
            begin
                flush_held();
                after_lf = 1'b0;
                emitted = {emitted, c};
            end
            else if (c == CH_LF)
            begin
                space_held = 1'b0;
                after_lf = 1'b1;
                if (md == MODE_PRE_LINE)
                begin
                    emitted = {emitted, CH_LF};
                    collapsing = 1'b0;
                end
                else
                begin
                    if (!collapsing)
                        emitted = {emitted, CH_SP};
                    collapsing = 1'b1;
                end
            end
            else if (c == CH_SP || c == CH_TAB)
            begin
                if (!after_lf)
                    space_held = 1'b1;
            end
            else
            begin
                after_lf = 1'b0;
                flush_held();
                emitted = {emitted, c};
                collapsing = 1'b0;
            end
        end

        if (last)
        begin
            flush_held();
            cr_seen = 1'b0;
            after_lf = 1'b0;
            space_held = 1'b0;
        end

        n = emitted.size();
        if (last && n == 0)
            n = 1;
        for (int k = 0; k < n; k++)
        begin
            r.has_char = (k < emitted.size());
            r.out_char = r.has_char ? emitted[k] : 8'h00;
            r.node_done = (k == n - 1) && last;
            r.collapse_next = (k == n - 1) && last && collapse_md && collapsing;
            r.last_of_run = (k == n - 1);
            results_due = {results_due, r};
        end
    endfunction

    function void check_result(result_t got);
        result_t want;

        if (results_due.size() == 0)
        begin
            report($sformatf("unexpected result: expected none, got %h", got));
            return;
        end
        want = results_due.pop_front();
        if (got.has_char !== want.has_char)
            report($sformatf("has_char: expected %0b, got %0b", want.has_char, got.has_char));
        if (got.out_char !== want.out_char)
            report($sformatf("out_char: expected %h, got %h", want.out_char, got.out_char));
        if (got.node_done !== want.node_done)
            report($sformatf("node_done: expected %0b, got %0b",
                             want.node_done, got.node_done));
        if (got.collapse_next !== want.collapse_next)
            report($sformatf("collapse_next: expected %0b, got %0b",
                             want.collapse_next, got.collapse_next));
        if (got.last_of_run !== want.last_of_run)
            report($sformatf("last_of_run: expected %0b, got %0b",
                             want.last_of_run, got.last_of_run));
    endfunction
endclass

module css_whitespace_collapse_stream_core_tb;

    // modes past pre-wrap behave as pre
    localparam logic [2:0] MODE_ODD5 = 3'd5;
    localparam logic [2:0] MODE_ODD6 = 3'd6;
    localparam logic [2:0] MODE_ODD7 = 3'd7;
    localparam int RANDOM_BYTES = 1450;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [7:0] ch = 8'h00;
    logic [2:0] mode = MODE_NORMAL;
    logic node_end = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic has_char;
    logic [7:0] out_char;
    logic node_done;
    logic collapse_next;
    logic last_of_run;

    logic calm = 1'b0;
    int stall_left = 0;

    ws_collapse_scoreboard sb = new();

    css_whitespace_collapse_stream_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .ch(ch),
        .mode(mode),
        .node_end(node_end),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .has_char(has_char),
        .out_char(out_char),
        .node_done(node_done),
        .collapse_next(collapse_next),
        .last_of_run(last_of_run)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int pick_gap();
        int r;

        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [7:0] pick_text_byte();
        int r;

        r = $urandom_range(0, 99);
        if (r < 25)
            return CH_SP;
        if (r < 35)
            return CH_TAB;
        if (r < 45)
            return CH_CR;
        if (r < 55)
            return CH_LF;
        if (r < 85)
            return 8'($urandom_range(8'h21, 8'h7E));
        return 8'($urandom_range(0, 255));
    endfunction

    // receiver: short stalls mostly, now and then a long one
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            int r;
            r = $urandom_range(0, 99);
            out_ready <= 1'b1;
            if (!calm && r < 25)
                stall_left <= $urandom_range(1, 3);
            else if (!calm && r < 28)
                stall_left <= $urandom_range(8, 30);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result('{has_char, out_char, node_done, collapse_next, last_of_run});
    end

    // called at a falling edge; returns at the falling edge where the next request may start
    task automatic send_byte(input logic [7:0] c, input logic [2:0] md, input logic last);
        int gap;

        in_valid <= 1'b1;
        ch <= c;
        mode <= md;
        node_end <= last;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(c, md, last);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    initial
    begin
        int sent;
        int node_len;
        int wait_cycles;
        logic [2:0] node_mode;
        logic [2:0] md;
        logic [7:0] c;
        logic lf_next;
        logic mixed;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_byte(8'h41, MODE_NORMAL, 1'b0);
        send_byte(8'h00, MODE_NORMAL, 1'b0);
        send_byte(8'hFF, MODE_NOWRAP, 1'b0);
        send_byte(CH_SP, MODE_NORMAL, 1'b0);
        send_byte(CH_TAB, MODE_NORMAL, 1'b0);
        send_byte(8'h62, MODE_NORMAL, 1'b0);
        // CR LF pair, then space after the linefeed is dropped
        send_byte(CH_CR, MODE_NORMAL, 1'b0);
        send_byte(CH_LF, MODE_NORMAL, 1'b0);
        send_byte(CH_SP, MODE_NORMAL, 1'b0);
        send_byte(8'h63, MODE_NORMAL, 1'b1);
        // held space flushed at node end, then collapse carried to the next node
        send_byte(CH_SP, MODE_PRE_LINE, 1'b1);
        send_byte(CH_SP, MODE_NORMAL, 1'b1);
        send_byte(CH_CR, MODE_PRE_LINE, 1'b0);
        send_byte(CH_CR, MODE_PRE_LINE, 1'b0);
        send_byte(CH_LF, MODE_PRE_LINE, 1'b0);
        send_byte(CH_TAB, MODE_PRE_LINE, 1'b0);
        send_byte(8'h64, MODE_PRE_LINE, 1'b0);
        send_byte(CH_SP, MODE_NOWRAP, 1'b0);
        // pre byte finds held whitespace mid-node
        send_byte(8'h78, MODE_PRE, 1'b0);
        send_byte(CH_TAB, MODE_PRE, 1'b0);
        send_byte(CH_CR, MODE_PRE_WRAP, 1'b0);
        send_byte(CH_LF, MODE_PRE_WRAP, 1'b1);
        send_byte(CH_CR, MODE_ODD7, 1'b0);
        send_byte(CH_SP, MODE_ODD5, 1'b0);
        send_byte(8'h7F, MODE_ODD6, 1'b1);

        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 9) == 0)
                calm = !calm;
            node_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                    : $urandom_range(1, 12);
            node_mode = ($urandom_range(0, 99) < 8) ? 3'($urandom_range(5, 7))
                                                     : 3'($urandom_range(0, 4));
            mixed = ($urandom_range(0, 9) == 0);
            lf_next = 1'b0;
            for (int k = 0; k < node_len; k++)
            begin
                c = lf_next ? CH_LF : pick_text_byte();
                lf_next = (c == CH_CR) && ($urandom_range(0, 1) == 1);
                md = mixed ? 3'($urandom_range(0, 7)) : node_mode;
                // occasional stray node end inside a node
                send_byte(c, md, (k == node_len - 1) || ($urandom_range(0, 49) == 0));
                sent++;
            end
        end

        in_valid <= 1'b0;
        wait_cycles = 0;
        while (sb.results_due.size() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (10) @(posedge clk);
        if (sb.results_due.size() != 0)
            sb.report($sformatf("%0d expected results never arrived",
                                sb.results_due.size()));

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
hdl/cssws_pkg.sv
hdl/cssws_in_stage.sv
hdl/cssws_proc.sv
hdl/cssws_res_queue.sv
hdl/css_whitespace_collapse_stream_core.sv
tb/css_whitespace_collapse_stream_core_tb.sv
